>>> hdl/dht_pkg.sv
// Shared types and constants of the double-hash key table.
// Used by the channel interfaces, the slot RAM, the top level and the checker.
package dht_pkg;

  // Default table geometry.
  localparam int TABLE_SIZE_DEF = 64;
  localparam int COUNT_W_DEF    = $clog2(TABLE_SIZE_DEF + 1);

  // Field widths fixed by the item format.
  localparam int ACT_W  = 3;
  localparam int KEY_W  = 32;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;
  localparam int CFG_W  = 7;

  // Hash multipliers.
  localparam logic [KEY_W-1:0] HASH_MUL1 = 32'd13;
  localparam logic [KEY_W-1:0] HASH_MUL2 = 32'd17;

  localparam logic [CFG_W-1:0] LOAD_PCT_RESET = 7'd80;

  // Actions.
  localparam logic [ACT_W-1:0] ACT_INSERT  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_PRESS   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_RELEASE = 3'd4;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_DONE      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] STAT_ZERO_KEY  = 2'd3;

  // Slot states.
  localparam logic [1:0] SLOT_UNUSED  = 2'd0;
  localparam logic [1:0] SLOT_USED    = 2'd1;
  localparam logic [1:0] SLOT_DELETED = 2'd2;

  typedef struct packed {
    logic [1:0]        st;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] tgt;
    logic [DATA_W-1:0] msg_down;
    logic [DATA_W-1:0] msg_up;
  } dht_entry_t;

endpackage

>>> hdl/dht_req_if.sv
// Request channel of the key table: valid/ready plus the operation payload.
// Depends on dht_pkg for field widths.
interface dht_req_if import dht_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [KEY_W-1:0]  key_code;
  logic [DATA_W-1:0] target_id;
  logic [DATA_W-1:0] message_down;
  logic [DATA_W-1:0] message_up;

  modport source (output valid, action, key_code, target_id, message_down, message_up,
                  input ready);
  modport sink   (input valid, action, key_code, target_id, message_down, message_up,
                  output ready);
endinterface

>>> hdl/dht_rsp_if.sv
// Response channel of the key table: valid/ready plus the result payload.
// Depends on dht_pkg for field widths.
interface dht_rsp_if import dht_pkg::*; #(parameter int COUNT_W = COUNT_W_DEF) ();
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic               found;
  logic               dispatch;
  logic [DATA_W-1:0]  hit_target;
  logic [DATA_W-1:0]  hit_message;
  logic [COUNT_W-1:0] entry_count_out;

  modport source (output valid, status, found, dispatch, hit_target, hit_message,
                  entry_count_out, input ready);
  modport sink   (input valid, status, found, dispatch, hit_target, hit_message,
                  entry_count_out, output ready);
endinterface

>>> hdl/dht_csub.sv
// Shared compare-and-subtract unit: reports a >= d and the difference.
// Standalone; used by the sequencer for probe wrap.
module dht_csub #(
  parameter int W = 7
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] d,
  output logic         ge,
  output logic [W-1:0] diff
);
  logic [W:0] wide;

  // Borrow out of the wide subtract gives the compare.
  assign wide = {1'b0, a} - {1'b0, d};
  assign ge   = ~wide[W];
  assign diff = wide[W-1:0];
endmodule

>>> hdl/dht_slot_ram.sv
// Slot storage: one write port, one read port with registered read data.
// Depends on dht_pkg for the slot entry type.
module dht_slot_ram import dht_pkg::*; #(
  parameter int DEPTH = TABLE_SIZE_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic       clk,
  input  logic       we,
  input  logic [AW-1:0] waddr,
  input  dht_entry_t wdata,
  input  logic       re,
  input  logic [AW-1:0] raddr,
  output dht_entry_t rdata
);
  dht_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

>>> hdl/double_hash_key_table_unit.sv
// Top level of the double-hash key table: sequencer, slot RAM and shared units.
// Depends on dht_pkg, dht_req_if, dht_rsp_if, dht_csub and dht_slot_ram.
//
//  channel  dir  handshake          payload
//  -------  ---  -----------------  -------------------------------------------
//  req      in   req.valid/ready    action, key_code, target_id, message_*
//  rsp      out  rsp.valid/ready    status, found, dispatch, hit_*, entry_count_out
//  cfg      in   cfg_we             cfg_data = load percentage limit
//
// Steps: an operation with a nonzero key and a known action reduces (key*13) mod
// TABLE_SIZE, then (key*17) mod (TABLE_SIZE-1) (reciprocal multiply, then remainder),
// issues the first read, probes one slot per cycle (1 to TABLE_SIZE slots), resolves
// and posts; the next transfer can come once the result has been posted.
// Zero keys and unknown actions go straight to posting.
// The RAM reads one slot per cycle, which sets the probe rate.
// Reset: a clearing pass marks every slot unused while req.ready is low;
// configuration writes are taken throughout.
// Stalls: one operation at a time; the result register holds while rsp.ready
// is low and the next request may be taken while it waits.
module double_hash_key_table_unit import dht_pkg::*; #(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  dht_req_if.sink          req,
  dht_rsp_if.source        rsp
);
  localparam int AW = $clog2(TABLE_SIZE);
  localparam int RW = AW + 1;
  localparam int CW = $clog2(TABLE_SIZE + 1);
  // Wide enough for 100*(count+1) and load_pct*TABLE_SIZE.
  localparam int LW = $clog2(128 * (TABLE_SIZE + 1));

  localparam logic [RW-1:0] MOD_N     = RW'(TABLE_SIZE);
  localparam logic [RW-1:0] MOD_N1    = RW'(TABLE_SIZE - 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_SIZE - 1);

  // Reciprocals for exact 32-bit division: q = (x * RCP) >> SH.
  localparam int SH_N  = KEY_W + $clog2(TABLE_SIZE);
  localparam int SH_N1 = KEY_W + $clog2(TABLE_SIZE - 1);
  localparam logic [63:0] RCP_N  =
    ((64'd1 << SH_N) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);
  localparam logic [63:0] RCP_N1 =
    ((64'd1 << SH_N1) + 64'(TABLE_SIZE - 1) - 64'd1) / 64'(TABLE_SIZE - 1);

  // Sequencer states.
  localparam logic [2:0] S_CLEAR   = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_MOD1    = 3'd2;
  localparam logic [2:0] S_MOD2    = 3'd3;
  localparam logic [2:0] S_PSTART  = 3'd4;
  localparam logic [2:0] S_PROBE   = 3'd5;
  localparam logic [2:0] S_RESOLVE = 3'd6;
  localparam logic [2:0] S_FIN     = 3'd7;

  // Control state (reset).
  logic [2:0]       state;
  logic [AW-1:0]    clr_addr;
  logic             phase;
  logic [AW-1:0]    n;
  logic             tomb_v;
  logic             free_v;
  logic             found;
  logic [CW-1:0]    count;
  logic [CFG_W-1:0] load_pct;

  // Operation datapath (no reset).
  logic [ACT_W-1:0]  act;
  logic [KEY_W-1:0]  key;
  logic [DATA_W-1:0] tgt;
  logic [DATA_W-1:0] mdn;
  logic [DATA_W-1:0] mup;
  logic [KEY_W-1:0]  shreg;
  logic [KEY_W-1:0]  quot;
  logic [AW-1:0]     h1;
  logic [AW-1:0]     stepv;
  logic [AW-1:0]     p;
  logic [AW-1:0]     tomb;
  dht_entry_t        hit_ent;
  logic [STAT_W-1:0] res_status;
  logic              res_found;
  logic              res_dispatch;
  logic [DATA_W-1:0] res_tgt;
  logic [DATA_W-1:0] res_msg;

  logic              in_xfer;
  logic              out_load;

  // Shared hash multiplier.
  logic [KEY_W:0]    rcp;
  logic [2*KEY_W:0]  rcp_prod;
  logic [KEY_W-1:0]  quot_next;
  logic [AW-1:0]     mod_div;
  logic [AW-1:0]     rem_val;

  // Shared probe-wrap unit hookup.
  logic [RW-1:0] cs_a;
  logic [RW-1:0] cs_d;
  logic          cs_ge;
  logic [RW-1:0] cs_diff;
  logic [RW-1:0] cs_sel;
  logic [AW-1:0] p_next;

  // Slot RAM hookup.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  dht_entry_t    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  dht_entry_t    ent;

  // Probe and resolve decisions.
  logic          st_unused;
  logic          st_del;
  logic          key_hit;
  logic          probe_last;
  logic [LW-1:0] need;
  logic [LW-1:0] lim;
  logic          full;

  assign req.ready = (state == S_IDLE);
  assign in_xfer   = req.valid && req.ready;
  assign out_load  = (state == S_FIN) && (!rsp.valid || rsp.ready);

  // One reciprocal multiplier serves both hashes: quotient first, then the remainder
  // from it. The remainder is below the divisor, so its low bits alone are exact.
  assign rcp       = (state == S_MOD2) ? RCP_N1[KEY_W:0] : RCP_N[KEY_W:0];
  assign rcp_prod  = (2*KEY_W+1)'(shreg) * (2*KEY_W+1)'(rcp);
  assign quot_next = (state == S_MOD2) ? KEY_W'(rcp_prod >> SH_N1) : KEY_W'(rcp_prod >> SH_N);
  assign mod_div   = (state == S_MOD2) ? MOD_N1[AW-1:0] : MOD_N[AW-1:0];
  assign rem_val   = shreg[AW-1:0] - quot[AW-1:0] * mod_div;

  // One compare-subtract wraps the probe position.
  assign cs_a = RW'(p) + RW'(stepv);
  assign cs_d = MOD_N;

  dht_csub #(.W(RW)) u_csub (
    .a    (cs_a),
    .d    (cs_d),
    .ge   (cs_ge),
    .diff (cs_diff)
  );

  assign cs_sel = cs_ge ? cs_diff : cs_a;
  assign p_next = cs_sel[AW-1:0];

  // Classify the slot read in the previous cycle.
  assign st_unused  = (ent.st == SLOT_UNUSED);
  assign st_del     = (ent.st == SLOT_DELETED);
  assign key_hit    = !st_unused && !st_del && (ent.key == key);
  assign probe_last = (n == LAST_SLOT);

  // Load check for a new key: 100*(count+1) >= load_pct*TABLE_SIZE, or no reusable slot seen.
  assign need = (LW'(count) + LW'(1)) * LW'(100);
  assign lim  = LW'(load_pct) * LW'(TABLE_SIZE);
  assign full = (need >= lim) || !(tomb_v || free_v);

  // Read: first slot in PSTART, then the next slot on the path each probe cycle.
  assign ram_re    = (state == S_PSTART) || (state == S_PROBE);
  assign ram_raddr = (state == S_PROBE) ? p_next : p;

  // Write: clearing pass, insert, replace or remove.
  always_comb begin
    ram_we             = 1'b0;
    ram_waddr          = p;
    ram_wdata.st       = SLOT_USED;
    ram_wdata.key      = key;
    ram_wdata.tgt      = tgt;
    ram_wdata.msg_down = mdn;
    ram_wdata.msg_up   = mup;
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
      ram_wdata.st = SLOT_UNUSED;
    end else if (state == S_RESOLVE) begin
      if (act == ACT_INSERT) begin
        if (found) begin
          ram_we = 1'b1;
        end else if (!full) begin
          ram_we    = 1'b1;
          ram_waddr = tomb_v ? tomb : p;
        end
      end else if (act == ACT_REMOVE && found) begin
        ram_we             = 1'b1;
        ram_wdata.st       = SLOT_DELETED;
        ram_wdata.tgt      = '0;
        ram_wdata.msg_down = '0;
        ram_wdata.msg_up   = '0;
      end
    end
  end

  dht_slot_ram #(.DEPTH(TABLE_SIZE), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ent)
  );

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      load_pct <= LOAD_PCT_RESET;
    end else if (cfg_we) begin
      load_pct <= cfg_data;
    end
  end

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      phase     <= 1'b0;
      n         <= '0;
      tomb_v    <= 1'b0;
      free_v    <= 1'b0;
      found     <= 1'b0;
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      // Post a new result from FIN, else drop the current one once it is taken.
      if (out_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == LAST_SLOT) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_xfer) begin
            phase <= 1'b0;
            // Unknown action or zero key: post the result straight away.
            if (req.action > ACT_RELEASE || req.key_code == '0) begin
              state <= S_FIN;
            end else begin
              state <= S_MOD1;
            end
          end
        end
        S_MOD1: begin
          phase <= ~phase;
          if (phase) begin
            state <= S_MOD2;
          end
        end
        S_MOD2: begin
          phase <= ~phase;
          if (phase) begin
            state <= S_PSTART;
          end
        end
        S_PSTART: begin
          n      <= '0;
          tomb_v <= 1'b0;
          free_v <= 1'b0;
          found  <= 1'b0;
          state  <= S_PROBE;
        end
        S_PROBE: begin
          if (st_unused) begin
            free_v <= 1'b1;
            state  <= S_RESOLVE;
          end else if (key_hit) begin
            found <= 1'b1;
            state <= S_RESOLVE;
          end else begin
            if (st_del) begin
              tomb_v <= 1'b1;
            end
            // Path exhausted after TABLE_SIZE slots.
            if (probe_last) begin
              state <= S_RESOLVE;
            end else begin
              n <= n + AW'(1);
            end
          end
        end
        S_RESOLVE: begin
          if (act == ACT_INSERT && !found && !full) begin
            count <= count + CW'(1);
          end else if (act == ACT_REMOVE && found && count != '0) begin
            count <= count - CW'(1);
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Operation datapath and result payload.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          act          <= req.action;
          key          <= req.key_code;
          tgt          <= req.target_id;
          mdn          <= req.message_down;
          mup          <= req.message_up;
          shreg        <= req.key_code * HASH_MUL1;
          res_status   <= (req.action > ACT_RELEASE) ? STAT_DONE : STAT_ZERO_KEY;
          res_found    <= 1'b0;
          res_dispatch <= 1'b0;
          res_tgt      <= '0;
          res_msg      <= '0;
        end
      end
      S_MOD1: begin
        if (!phase) begin
          quot <= quot_next;
        end else begin
          h1    <= rem_val;
          shreg <= key * HASH_MUL2;
        end
      end
      S_MOD2: begin
        if (!phase) begin
          quot <= quot_next;
        end else begin
          stepv <= rem_val | AW'(1);
          p     <= h1;
        end
      end
      S_PROBE: begin
        if (key_hit) begin
          hit_ent <= ent;
        end else if (!st_unused) begin
          // Remember the first tombstone on the path for reuse.
          if (st_del && !tomb_v) begin
            tomb <= p;
          end
          if (!probe_last) begin
            p <= p_next;
          end
        end
      end
      S_RESOLVE: begin
        res_found    <= found;
        res_dispatch <= 1'b0;
        res_tgt      <= '0;
        res_msg      <= '0;
        if (act == ACT_INSERT) begin
          res_status <= (!found && full) ? STAT_FULL : STAT_DONE;
        end else if (!found) begin
          res_status <= STAT_NOT_FOUND;
        end else if (act == ACT_REMOVE) begin
          res_status <= STAT_DONE;
        end else begin
          res_status <= STAT_DONE;
          res_tgt    <= hit_ent.tgt;
          if (act == ACT_PRESS) begin
            res_msg      <= hit_ent.msg_down;
            res_dispatch <= (hit_ent.tgt != '0) && (hit_ent.msg_down != '0);
          end else if (act == ACT_RELEASE) begin
            res_msg      <= hit_ent.msg_up;
            res_dispatch <= (hit_ent.tgt != '0) && (hit_ent.msg_up != '0);
          end
        end
      end
      S_FIN: begin
        if (out_load) begin
          rsp.status          <= res_status;
          rsp.found           <= res_found;
          rsp.dispatch        <= res_dispatch;
          rsp.hit_target      <= res_tgt;
          rsp.hit_message     <= res_msg;
          rsp.entry_count_out <= count;
        end
      end
      default: begin
      end
    endcase
  end
endmodule

>>> hdl/dht_checker.sv
// Port-level checker for the key table, bound to the top level.
// Depends on dht_pkg and double_hash_key_table_unit.
module dht_checker import dht_pkg::*; #(
  parameter int COUNT_W = COUNT_W_DEF
) (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic [STAT_W-1:0]  rsp_status,
  input logic               rsp_found,
  input logic               rsp_dispatch,
  input logic [DATA_W-1:0]  rsp_hit_target,
  input logic [DATA_W-1:0]  rsp_hit_message,
  input logic [COUNT_W-1:0] rsp_entry_count
);
  // Reset starts the clearing pass: no request taken, no result shown.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !rsp_valid && !req_ready)
    else $error("request or response active right after reset");

  // One operation at a time: no transfer in the cycle after a transfer.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request ready right after a transfer");

  // A dispatch needs a found entry with target and message both set.
  a_dispatch_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_dispatch) |-> (rsp_found && rsp_status == STAT_DONE &&
      rsp_hit_target != '0 && rsp_hit_message != '0))
    else $error("dispatch without a complete found entry");

  // A stalled result holds.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status) &&
      $stable(rsp_found) && $stable(rsp_dispatch) && $stable(rsp_hit_target) &&
      $stable(rsp_hit_message) && $stable(rsp_entry_count)))
    else $error("stalled response changed");
endmodule

bind double_hash_key_table_unit dht_checker #(.COUNT_W(CW)) u_dht_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_status      (rsp.status),
  .rsp_found       (rsp.found),
  .rsp_dispatch    (rsp.dispatch),
  .rsp_hit_target  (rsp.hit_target),
  .rsp_hit_message (rsp.hit_message),
  .rsp_entry_count (rsp.entry_count_out)
);

>>> bench/dht_tb_pkg.sv
// Checker for the double-hash key table: reply format and a mirror of the slot table.
// Depends on dht_pkg for field widths, action and status codes, slot states and table size.
package dht_tb_pkg;
  import dht_pkg::*;

  typedef struct packed {
    logic [STAT_W-1:0]      status;
    logic                   found;
    logic                   dispatch;
    logic [DATA_W-1:0]      hit_target;
    logic [DATA_W-1:0]      hit_message;
    logic [COUNT_W_DEF-1:0] entry_count;
  } table_reply_t;

  class key_table_mirror;
    logic [1:0]        slot_state [TABLE_SIZE_DEF];
    logic [KEY_W-1:0]  slot_key   [TABLE_SIZE_DEF];
    logic [DATA_W-1:0] slot_tgt   [TABLE_SIZE_DEF];
    logic [DATA_W-1:0] slot_down  [TABLE_SIZE_DEF];
    logic [DATA_W-1:0] slot_up    [TABLE_SIZE_DEF];
    int unsigned       used;
    logic [CFG_W-1:0]  load_limit;
    table_reply_t      pending_replies [$];
    int unsigned       mismatches;

    function new();
      for (int i = 0; i < TABLE_SIZE_DEF; i++) begin
        slot_state[i] = SLOT_UNUSED;
        slot_key[i]   = '0;
        slot_tgt[i]   = '0;
        slot_down[i]  = '0;
        slot_up[i]    = '0;
      end
      used       = 0;
      load_limit = LOAD_PCT_RESET;
      mismatches = 0;
    endfunction

    function void set_load_limit(logic [CFG_W-1:0] value);
      load_limit = value;
    endfunction

    // Walk the double-hash path; stop at a match or an unused slot, at most one lap.
    function bit find_key(input logic [KEY_W-1:0] k, output int hit, output int tomb,
                          output int free_at);
      logic [KEY_W-1:0] h1;
      logic [KEY_W-1:0] h2;
      int               pos;
      int               stride;
      bit               done;
      h1      = k * HASH_MUL1;
      h2      = k * HASH_MUL2;
      pos     = int'(h1 % TABLE_SIZE_DEF);
      stride  = int'(h2 % (TABLE_SIZE_DEF - 1)) | 1;
      hit     = -1;
      tomb    = -1;
      free_at = -1;
      done    = 1'b0;
      for (int n = 0; n < TABLE_SIZE_DEF && !done; n++) begin
        if (slot_state[pos] == SLOT_UNUSED) begin
          free_at = pos;
          done    = 1'b1;
        end else if (slot_state[pos] == SLOT_DELETED) begin
          if (tomb < 0) tomb = pos;
        end else if (slot_key[pos] == k) begin
          hit  = pos;
          done = 1'b1;
        end
        if (!done) pos = (pos + stride) % TABLE_SIZE_DEF;
      end
      return hit >= 0;
    endfunction

    // Apply one accepted request to the mirror and queue the reply it must produce.
    function void note_request(logic [ACT_W-1:0] act, logic [KEY_W-1:0] k,
                               logic [DATA_W-1:0] tgt, logic [DATA_W-1:0] mdn,
                               logic [DATA_W-1:0] mup);
      table_reply_t r;
      int           hit;
      int           tomb;
      int           free_at;
      int           dst;
      bit           present;
      int unsigned  need;
      int unsigned  lim;
      r = '0;
      if (act <= ACT_RELEASE && k == '0) begin
        r.status = STAT_ZERO_KEY;
      end else if (act <= ACT_RELEASE) begin
        present = find_key(k, hit, tomb, free_at);
        r.found = present;
        if (act == ACT_INSERT) begin
          if (present) begin
            slot_tgt[hit]  = tgt;
            slot_down[hit] = mdn;
            slot_up[hit]   = mup;
          end else begin
            dst  = (tomb >= 0) ? tomb : free_at;
            need = 100 * (used + 1);
            lim  = load_limit * TABLE_SIZE_DEF;
            if (need >= lim || dst < 0) begin
              r.status = STAT_FULL;
            end else begin
              slot_state[dst] = SLOT_USED;
              slot_key[dst]   = k;
              slot_tgt[dst]   = tgt;
              slot_down[dst]  = mdn;
              slot_up[dst]    = mup;
              used++;
            end
          end
        end else if (!present) begin
          r.status = STAT_NOT_FOUND;
        end else if (act == ACT_REMOVE) begin
          slot_state[hit] = SLOT_DELETED;
          slot_tgt[hit]   = '0;
          slot_down[hit]  = '0;
          slot_up[hit]    = '0;
          if (used > 0) used--;
        end else begin
          r.hit_target = slot_tgt[hit];
          if (act == ACT_PRESS) r.hit_message = slot_down[hit];
          else if (act == ACT_RELEASE) r.hit_message = slot_up[hit];
          if (act != ACT_QUERY && r.hit_target != '0 && r.hit_message != '0)
            r.dispatch = 1'b1;
        end
      end
      r.entry_count = COUNT_W_DEF'(used);
      pending_replies.push_back(r);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("[%0t] mismatch on %s: got 0x%08h, expected 0x%08h", $time, what, got, want);
    endtask

    // Compare one delivered reply with the oldest queued one.
    task check_result(table_reply_t got);
      table_reply_t want;
      if (pending_replies.size() == 0) begin
        report_mismatch("reply with none pending", 32'(got.status), '0);
      end else begin
        want = pending_replies.pop_front();
        if (got.status != want.status)
          report_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.found != want.found)
          report_mismatch("found", 32'(got.found), 32'(want.found));
        if (got.dispatch != want.dispatch)
          report_mismatch("dispatch", 32'(got.dispatch), 32'(want.dispatch));
        if (got.hit_target != want.hit_target)
          report_mismatch("hit_target", got.hit_target, want.hit_target);
        if (got.hit_message != want.hit_message)
          report_mismatch("hit_message", got.hit_message, want.hit_message);
        if (got.entry_count != want.entry_count)
          report_mismatch("entry_count_out", 32'(got.entry_count), 32'(want.entry_count));
      end
    endtask
  endclass

endpackage

>>> bench/double_hash_key_table_unit_tb.sv
// Self-checking bench for double_hash_key_table_unit: directed and random table traffic.
// Depends on dht_pkg, dht_tb_pkg, the two channel interfaces and the unit itself.
module double_hash_key_table_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dht_pkg::*;
  import dht_tb_pkg::*;

  // Timeout many times the worst item plus the random idle gaps on each side.
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int          POOL_SIZE   = 96;
  localparam int          HOLD_AFTER  = 300;
  localparam int          LONG_HOLD   = 800;
  localparam int          DRAIN_TAIL  = TABLE_SIZE_DEF + 80;
  localparam int          MAX_GAP     = 8;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_data;

  dht_req_if req_ch ();
  dht_rsp_if rsp_ch ();

  double_hash_key_table_unit dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req_ch),
    .rsp      (rsp_ch)
  );

  key_table_mirror  mirror = new();
  logic [KEY_W-1:0] key_pool [POOL_SIZE];
  bit               send_gaps = 1'b1;
  bit               take_gaps = 1'b1;
  int unsigned      cycle_count = 0;
  int unsigned      replies_seen = 0;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Hard stop in case the unit hangs or a reply never comes.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding", cycle_count,
               mirror.pending_replies.size());
      $display("double_hash_key_table_unit_tb: FAIL");
      $finish;
    end
  end

  // Present one request and hold it until the unit takes it; the mirror advances on
  // the transfer edge. Valid stays high afterwards so back-to-back items need no gap.
  task automatic send_op(logic [ACT_W-1:0] act, logic [KEY_W-1:0] k,
                         logic [DATA_W-1:0] tgt, logic [DATA_W-1:0] mdn,
                         logic [DATA_W-1:0] mup);
    int gap;
    gap = send_gaps ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.action       <= act;
    req_ch.key_code     <= k;
    req_ch.target_id    <= tgt;
    req_ch.message_down <= mdn;
    req_ch.message_up   <= mup;
    do @(posedge clk); while (!(req_ch.valid === 1'b1 && req_ch.ready === 1'b1));
    mirror.note_request(act, k, tgt, mdn, mup);
    // Flip between gappy and back-to-back stretches now and then.
    if ($urandom_range(0, 49) == 0) send_gaps = !send_gaps;
  endtask

  // Drop valid and wait until every queued reply has been delivered.
  task automatic drain_replies();
    req_ch.valid <= 1'b0;
    while (mirror.pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Single-cycle register write; only called with the unit idle.
  task automatic write_load(logic [CFG_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    mirror.set_load_limit(value);
  endtask

  // Payload word: zero now and then so the no-target and no-message cases show up.
  function automatic logic [DATA_W-1:0] pick_word();
    return ($urandom_range(0, 5) == 0) ? '0 : DATA_W'($urandom);
  endfunction

  // Mostly operations on a small key pool so hits, tombstones and collisions are common;
  // a few zero keys, fresh random keys and unknown actions mixed in.
  task automatic random_op();
    int               pick;
    int               kind;
    logic [ACT_W-1:0] act;
    logic [KEY_W-1:0] k;
    pick = $urandom_range(0, 99);
    if (pick < 35) act = ACT_INSERT;
    else if (pick < 55) act = ACT_REMOVE;
    else if (pick < 67) act = ACT_QUERY;
    else if (pick < 81) act = ACT_PRESS;
    else if (pick < 96) act = ACT_RELEASE;
    else act = ACT_RELEASE + ACT_W'($urandom_range(1, 3));
    kind = $urandom_range(0, 99);
    if (kind < 3) k = '0;
    else if (kind < 10) k = KEY_W'($urandom);
    else k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    send_op(act, k, pick_word(), pick_word(), pick_word());
  endtask

  task automatic random_run(int count);
    for (int i = 0; i < count; i++) random_op();
  endtask

  // Reply side: random ready stalls, one long hold-off after a few hundred replies
  // while the sender keeps offering, so the unit backs up and drops req.ready.
  initial begin
    int           stall;
    table_reply_t got;
    rsp_ch.ready <= 1'b0;
    forever begin
      if (replies_seen == HOLD_AFTER) stall = LONG_HOLD;
      else stall = take_gaps ? $urandom_range(0, MAX_GAP) : 0;
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1));
      got.status      = rsp_ch.status;
      got.found       = rsp_ch.found;
      got.dispatch    = rsp_ch.dispatch;
      got.hit_target  = rsp_ch.hit_target;
      got.hit_message = rsp_ch.hit_message;
      got.entry_count = rsp_ch.entry_count_out;
      mirror.check_result(got);
      replies_seen++;
      if ($urandom_range(0, 40) == 0) take_gaps = !take_gaps;
    end
  end

  initial begin
    logic [KEY_W-1:0] stray;
    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_data            <= '0;
    req_ch.valid        <= 1'b0;
    req_ch.action       <= ACT_INSERT;
    req_ch.key_code     <= '0;
    req_ch.target_id    <= '0;
    req_ch.message_down <= '0;
    req_ch.message_up   <= '0;

    // Pool keys: the two marker-like codes first, then random nonzero codes.
    key_pool[0] = 32'hffff_ffff;
    key_pool[1] = 32'hffff_fffe;
    for (int i = 2; i < POOL_SIZE; i++) begin
      key_pool[i] = KEY_W'($urandom);
      if (key_pool[i] == '0) key_pool[i] = KEY_W'(i);
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty-table miss, marker-like keys as ordinary keys, replace,
    // dispatch with and without target or message, remove and tombstone reuse.
    send_op(ACT_INSERT,  '0,           32'h1111_1111, 32'h2222_2222, 32'h3333_3333);
    send_op(ACT_QUERY,   32'hffff_ffff, '0, '0, '0);
    send_op(ACT_INSERT,  32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_op(ACT_INSERT,  32'hffff_fffe, 32'h0000_0001, '0, 32'h0000_0002);
    send_op(ACT_PRESS,   32'hffff_ffff, '0, '0, '0);
    send_op(ACT_RELEASE, 32'hffff_fffe, '0, '0, '0);
    send_op(ACT_PRESS,   32'hffff_fffe, '0, '0, '0);
    send_op(ACT_INSERT,  32'hffff_ffff, '0, 32'h0000_0005, 32'h0000_0006);
    send_op(ACT_RELEASE, 32'hffff_ffff, '0, '0, '0);
    send_op(ACT_QUERY,   32'hffff_fffe, '0, '0, '0);
    send_op(ACT_REMOVE,  32'hffff_fffe, '0, '0, '0);
    send_op(ACT_REMOVE,  32'hffff_fffe, '0, '0, '0);
    send_op(ACT_INSERT,  32'hffff_fffe, 32'hdead_beef, 32'h0bad_f00d, 32'h8000_0000);
    // Zero key on remove, query, press and release, then the unknown action codes.
    send_op(ACT_PRESS,   '0, '0, '0, '0);
    send_op(ACT_REMOVE,  '0, '0, '0, '0);
    send_op(ACT_QUERY,   '0, '0, '0, '0);
    send_op(ACT_RELEASE, '0, '0, '0, '0);
    send_op(ACT_RELEASE + 3'd1, 32'hffff_ffff, '0, '0, '0);
    send_op(ACT_RELEASE + 3'd2, 32'hffff_ffff, '0, '0, '0);
    send_op(ACT_RELEASE + 3'd3, 32'hffff_ffff, '0, '0, '0);
    send_op(ACT_RELEASE + 3'd3, '0, '0, '0, '0);
    send_op(ACT_RELEASE, 32'h0001_0041, '0, '0, '0);
    send_op(ACT_INSERT,  32'h8000_0001, '0, '0, '0);

    // Load limit zero: new keys refused, replace still allowed.
    drain_replies();
    write_load('0);
    send_op(ACT_INSERT, key_pool[10], 32'h0000_00aa, 32'h0000_00bb, 32'h0000_00cc);
    send_op(ACT_INSERT, 32'hffff_ffff, 32'h0000_0007, 32'h0000_0008, 32'h0000_0009);
    send_op(ACT_QUERY,  key_pool[10], '0, '0, '0);

    // Top register value never refuses: fill every slot, then hit the
    // no-free-slot refusal and misses that walk a full lap.
    drain_replies();
    write_load(7'h7f);
    for (int i = 0; i < POOL_SIZE && mirror.used < TABLE_SIZE_DEF; i++)
      send_op(ACT_INSERT, key_pool[i], pick_word(), pick_word(), pick_word());
    stray = 32'h5a5a_0000 | KEY_W'($urandom_range(1, 16'hffff));
    send_op(ACT_QUERY,   stray, '0, '0, '0);
    send_op(ACT_PRESS,   stray, '0, '0, '0);
    send_op(ACT_RELEASE, stray, '0, '0, '0);
    send_op(ACT_INSERT,  stray, 32'h0000_0011, 32'h0000_0022, 32'h0000_0033);
    send_op(ACT_REMOVE,  key_pool[5], '0, '0, '0);
    send_op(ACT_INSERT,  stray, 32'h0000_0011, 32'h0000_0022, 32'h0000_0033);
    send_op(ACT_PRESS,   stray, '0, '0, '0);
    random_run(250);

    // Sweep the load limit: lowest useful, full scale, half, random, reset value.
    drain_replies();
    write_load(7'd1);
    random_run(100);
    drain_replies();
    write_load(7'd100);
    random_run(350);
    drain_replies();
    write_load(7'd50);
    random_run(250);
    for (int phase = 0; phase < 3; phase++) begin
      drain_replies();
      write_load(CFG_W'($urandom_range(1, 100)));
      random_run(200);
    end
    drain_replies();
    write_load(LOAD_PCT_RESET);
    random_run(250);

    // Wait out any stray late reply before the verdict.
    drain_replies();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (mirror.mismatches == 0 && mirror.pending_replies.size() == 0) begin
      $display("double_hash_key_table_unit_tb: PASS");
    end else begin
      $display("double_hash_key_table_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/dht_pkg.sv
hdl/dht_req_if.sv
hdl/dht_rsp_if.sv
hdl/dht_csub.sv
hdl/dht_slot_ram.sv
hdl/double_hash_key_table_unit.sv
hdl/dht_checker.sv
bench/dht_tb_pkg.sv
bench/double_hash_key_table_unit_tb.sv
